// File: src/csu_pkg.sv
// Shared types, constants and a helper function for the counting semaphore unit.
`default_nettype none

package csu_pkg;

    // Table geometry
    localparam int NUM_SEMS    = 32;
    localparam int NUM_THREADS = 32;
    localparam int SEM_IDW     = 5;
    localparam int SEM_DEPTH   = 1 << SEM_IDW;
    localparam int TID_W       = 6;
    localparam int CNT_W       = 32;
    localparam int MAP_W       = 32;
    localparam int MAP_IDXW    = 5;

    // Request codes
    typedef enum logic [1:0] {
        REQ_INIT    = 2'd0,
        REQ_TRYWAIT = 2'd1,
        REQ_WAIT    = 2'd2,
        REQ_POST    = 2'd3
    } req_code_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BLOCK   = 2'd1,
        ST_INVALID = 2'd2,
        ST_QUEUED  = 2'd3
    } status_code_t;

    // Request beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [SEM_IDW-1:0] sem_id;
        logic [TID_W-1:0]   thread_id;
        logic [CNT_W-1:0]   init_value;
    } req_item_t;

    // Response beat
    typedef struct packed {
        logic [1:0]       status;
        logic             woken_valid;
        logic [TID_W-1:0] woken_thread;
    } rsp_item_t;

    // Write-back of one semaphore entry
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] count;
        logic [MAP_W-1:0] bitmap;
    } entry_upd_t;

    // Index of the lowest set bit; isolate it, then encode the one-hot word
    function automatic logic [MAP_IDXW-1:0] lowest_idx(input logic [MAP_W-1:0] v);
        logic [MAP_W-1:0]    low;
        logic [MAP_IDXW-1:0] idx;
        low = v & (~v + MAP_W'(1));
        idx = '0;
        for (int i = 0; i < MAP_W; i++) begin
            for (int j = 0; j < MAP_IDXW; j++) begin
                if (((i >> j) & 1) == 1) begin
                    idx[j] = idx[j] | low[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: src/csu_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none

module csu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/csu_alu.sv
// Next-state and response logic for one semaphore request.
`default_nettype none

module csu_alu (
    input  wire csu_pkg::req_item_t             req,
    input  wire logic [csu_pkg::NUM_SEMS-1:0]   alloc_mask,
    input  wire logic [csu_pkg::CNT_W-1:0]      cur_count,
    input  wire logic [csu_pkg::MAP_W-1:0]      cur_bitmap,
    output csu_pkg::entry_upd_t                 upd,
    output csu_pkg::rsp_item_t                  rsp
);

    logic                          sem_ok;
    logic                          tid_ok;
    logic [csu_pkg::TID_W-1:0]     tid_m1;
    logic [csu_pkg::MAP_W-1:0]     tid_bit;
    logic [csu_pkg::MAP_IDXW-1:0]  low_idx;
    logic [csu_pkg::MAP_W-1:0]     low_bit;

    // Check the semaphore id against the table size and the allocation mask
    always_comb
    begin
        sem_ok = 1'b0;
        if (32'(req.sem_id) < 32'(csu_pkg::NUM_SEMS))
        begin
            sem_ok = alloc_mask[req.sem_id[$clog2(csu_pkg::NUM_SEMS > 1 ?
                                 csu_pkg::NUM_SEMS : 2)-1:0]];
        end
    end

    // Decode the caller's waiter bit and the lowest waiter
    assign tid_ok  = (req.thread_id != '0) &&
                     (32'(req.thread_id) <= 32'(csu_pkg::NUM_THREADS));
    assign tid_m1  = req.thread_id - csu_pkg::TID_W'(1);
    assign tid_bit = csu_pkg::MAP_W'(1) << tid_m1[csu_pkg::MAP_IDXW-1:0];
    assign low_idx = csu_pkg::lowest_idx(cur_bitmap);
    assign low_bit = csu_pkg::MAP_W'(1) << low_idx;

    // Apply the request
    always_comb
    begin
        upd.we           = 1'b0;
        upd.count        = cur_count;
        upd.bitmap       = cur_bitmap;
        rsp.status       = csu_pkg::ST_OK;
        rsp.woken_valid  = 1'b0;
        rsp.woken_thread = '0;
        if (!sem_ok)
        begin
            rsp.status = csu_pkg::ST_INVALID;
        end
        else
        begin
            case (req.req_type)
                csu_pkg::REQ_INIT:
                begin
                    upd.we    = 1'b1;
                    upd.count = req.init_value;
                end
                csu_pkg::REQ_TRYWAIT:
                begin
                    if (cur_count != '0)
                    begin
                        upd.we    = 1'b1;
                        upd.count = cur_count - csu_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        rsp.status = csu_pkg::ST_BLOCK;
                    end
                end
                csu_pkg::REQ_WAIT:
                begin
                    if (cur_count != '0)
                    begin
                        upd.we    = 1'b1;
                        upd.count = cur_count - csu_pkg::CNT_W'(1);
                    end
                    else if (tid_ok)
                    begin
                        upd.we     = 1'b1;
                        upd.bitmap = cur_bitmap | tid_bit;
                        rsp.status = csu_pkg::ST_QUEUED;
                    end
                    else
                    begin
                        rsp.status = csu_pkg::ST_BLOCK;
                    end
                end
                csu_pkg::REQ_POST:
                begin
                    if (cur_bitmap != '0)
                    begin
                        upd.we           = 1'b1;
                        upd.bitmap       = cur_bitmap & ~low_bit;
                        rsp.woken_valid  = 1'b1;
                        rsp.woken_thread = csu_pkg::TID_W'(low_idx) + csu_pkg::TID_W'(1);
                    end
                    else if (cur_count != '1)
                    begin
                        upd.we    = 1'b1;
                        upd.count = cur_count + csu_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp.status = csu_pkg::ST_INVALID;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/counting_semaphore_unit.sv
// Top level of the counting semaphore unit: request stage, entry RAMs and response.
//
// Usage:
//   Request channel: drive req and raise start; a beat is taken at a rising
//   edge where start is high and busy is low.
//   Response channel: done is high for exactly one cycle with the response
//   beat on rsp. The receiver cannot stall; it must take the beat then.
//   Configuration: cfg_we with cfg_wdata loads the allocation mask; write it
//   only while no request is in flight.
// Timing:
//   A request taken at an edge has its entry read into the registered outputs
//   of the count and waiter RAMs; the update stage then computes the new entry,
//   written back at the edge that also registers the response on rsp with done
//   high. busy is high for the one cycle the request holds the update stage;
//   the read-modify-write loop takes a new request only after the write-back.
// Reset:
//   rst_n clears the allocation mask, the per-entry valid bits (so every
//   count and waiter bitmap reads as zero) and the pipeline; no clearing
//   pass is needed and a request may be issued right after reset.
`default_nettype none

module counting_semaphore_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire csu_pkg::req_item_t               req,
    output logic                                  done,
    output csu_pkg::rsp_item_t                    rsp,
    input  wire logic                             cfg_we,
    input  wire logic [csu_pkg::NUM_SEMS-1:0]     cfg_wdata
);

    logic                                accept;
    logic                                stage_vld_reg;
    csu_pkg::req_item_t                  req_reg;
    logic [csu_pkg::NUM_SEMS-1:0]        alloc_mask_reg;
    logic [csu_pkg::SEM_DEPTH-1:0]       entry_vld_reg;
    logic [csu_pkg::SEM_DEPTH-1:0]       entry_vld_next;
    logic                                rd_vld_reg;
    logic [csu_pkg::CNT_W-1:0]           cnt_rdata;
    logic [csu_pkg::MAP_W-1:0]           map_rdata;
    logic [csu_pkg::CNT_W-1:0]           cur_count;
    logic [csu_pkg::MAP_W-1:0]           cur_bitmap;
    logic                                wr_en;
    csu_pkg::entry_upd_t                 upd;
    csu_pkg::rsp_item_t                  alu_rsp;
    logic                                done_reg;
    csu_pkg::rsp_item_t                  rsp_reg;

    // Take a request beat only when the update stage is empty
    assign accept = start && !stage_vld_reg;
    assign busy   = stage_vld_reg;
    assign wr_en  = stage_vld_reg && upd.we;

    // Hold the allocation mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            alloc_mask_reg <= cfg_wdata;
        end
    end

    // Mark entries as written once their first update lands
    always_comb
    begin
        entry_vld_next = entry_vld_reg;
        if (wr_en)
        begin
            entry_vld_next[req_reg.sem_id] = 1'b1;
        end
    end

    // Advance the control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            entry_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= accept;
            entry_vld_reg <= entry_vld_next;
            done_reg      <= stage_vld_reg;
            if (accept)
            begin
                rd_vld_reg <= entry_vld_reg[req.sem_id];
            end
        end
    end

    // Capture request and response payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (stage_vld_reg)
        begin
            rsp_reg <= alu_rsp;
        end
    end

    // Count and waiter-bitmap storage
    csu_ram #(
        .WIDTH (csu_pkg::CNT_W),
        .DEPTH (csu_pkg::SEM_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (req_reg.sem_id),
        .wdata (upd.count),
        .re    (accept),
        .raddr (req.sem_id),
        .rdata (cnt_rdata)
    );

    csu_ram #(
        .WIDTH (csu_pkg::MAP_W),
        .DEPTH (csu_pkg::SEM_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (req_reg.sem_id),
        .wdata (upd.bitmap),
        .re    (accept),
        .raddr (req.sem_id),
        .rdata (map_rdata)
    );

    // Read unwritten entries as their reset value
    assign cur_count  = rd_vld_reg ? cnt_rdata : '0;
    assign cur_bitmap = rd_vld_reg ? map_rdata : '0;

    csu_alu u_alu (
        .req        (req_reg),
        .alloc_mask (alloc_mask_reg),
        .cur_count  (cur_count),
        .cur_bitmap (cur_bitmap),
        .upd        (upd),
        .rsp        (alu_rsp)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // A response beat always follows a request held in the update stage
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without a request in the update stage");

    // The update stage holds one request for exactly one cycle
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("update stage held longer than one cycle");

    // An accepted beat enters the update stage
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter the update stage");

    // A released waiter comes with status ok and a real thread number
    a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.woken_valid) |->
            (rsp.status == csu_pkg::ST_OK && rsp.woken_thread != '0))
        else $error("woken thread reported with bad status or number");

    // An invalid request leaves the entry RAMs untouched
    a_invalid_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == csu_pkg::ST_INVALID) |-> $past(!wr_en))
        else $error("invalid request wrote an entry");
`endif

endmodule

`default_nettype wire
